// ----- hw/rtl/rational_arith_reduce_top_defines.svh -----
// Assertion macros used by the rational reduction controller.
`ifndef RATIONAL_ARITH_REDUCE_TOP_DEFINES_SVH
`define RATIONAL_ARITH_REDUCE_TOP_DEFINES_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define RAR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk outside reset.
`define RAR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rar_pkg.sv -----
// Shared codes, widths and controller/datapath interface types.
package rar_pkg;

    // Operation codes carried on the input tuser
    localparam logic [2:0] FUNC_ADD = 3'd0;
    localparam logic [2:0] FUNC_SUB = 3'd1;
    localparam logic [2:0] FUNC_MUL = 3'd2;
    localparam logic [2:0] FUNC_DIV = 3'd3;
    localparam logic [2:0] FUNC_INC = 3'd4;
    localparam logic [2:0] FUNC_DEC = 3'd5;

    localparam int FUNC_W    = 3;
    localparam int RES_NUM_W = 33;
    localparam int RES_DEN_W = 31;

    // Which product the shared multiplier forms
    typedef enum logic [1:0] {
        MS_NUM0,
        MS_NUM1,
        MS_DEN
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     comb;
        logic     mag;
        logic     gcd_step;
        logic     div_init;
        logic     div_step;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic gcd_done;
        logic div_done;
    } t_dp_status;

endpackage

// ----- hw/rtl/rar_dp.sv -----
// Datapath: operand capture, shared multiplier, binary GCD and dual divider.
module rar_dp import rar_pkg::*; #(
    parameter int WIDTH = 16
) (
    input  logic                        i_clk,
    input  t_dp_cmd                     i_cmd,
    input  logic [FUNC_W-1:0]           i_func,
    input  logic signed [WIDTH-1:0]     i_a_num,
    input  logic signed [WIDTH-1:0]     i_a_den,
    input  logic signed [WIDTH-1:0]     i_b_num,
    input  logic signed [WIDTH-1:0]     i_b_den,
    output t_dp_status                  o_status,
    output logic signed [RES_NUM_W-1:0] o_res_num,
    output logic [RES_DEN_W-1:0]        o_res_den,
    output logic                        o_div_by_zero
);

    localparam int PW = 2 * WIDTH;
    localparam int RW = (2 * WIDTH + 1 > 64) ? 64 : 2 * WIDTH + 1;
    localparam int KW = $clog2(RW);
    localparam int CW = $clog2(RW + 1);
    localparam int OW = (RW > RES_NUM_W) ? RW : RES_NUM_W;
    localparam int DW = (RW > RES_DEN_W) ? RW : RES_DEN_W;

    logic [FUNC_W-1:0]       r_func;
    logic signed [WIDTH-1:0] r_an, r_ad, r_bn, r_bd;
    logic signed [PW-1:0]    r_p0, r_p1, r_pd;
    logic signed [RW-1:0]    r_rn, r_rd;
    logic                    r_neg, r_zero;
    logic [RW-1:0]           r_u, r_v, r_g;
    logic [KW-1:0]           r_k;
    logic [RW-1:0]           r_qn, r_qd, r_mn, r_md;
    logic [CW-1:0]           r_cnt;
    logic signed [RES_NUM_W-1:0] r_res_num;
    logic [RES_DEN_W-1:0]    r_res_den;
    logic                    r_dz;

    logic signed [WIDTH-1:0] w_mx, w_my;
    logic signed [PW-1:0]    w_prod;
    logic signed [RW-1:0]    w_rn, w_rd;
    logic [RW-1:0]           w_nmag, w_dmag;
    logic [RW-1:0]           w_diff;
    logic                    w_u_gt;
    logic                    w_gcd_done;
    logic [RW:0]             w_tn, w_td;
    logic                    w_gen, w_ged;
    logic [RW:0]             w_tn_sub, w_td_sub;
    logic [OW-1:0]           w_qn_ext, w_num_s;
    logic [DW-1:0]           w_qd_ext;

    // Select multiplier operands for the current product
    always_comb begin
        case (i_cmd.mul_sel)
            MS_NUM0: begin
                w_mx = r_an;
                w_my = (r_func == FUNC_MUL) ? r_bn : r_bd;
            end
            MS_NUM1: begin
                w_mx = r_bn;
                w_my = r_ad;
            end
            MS_DEN: begin
                w_mx = r_ad;
                w_my = (r_func == FUNC_DIV) ? r_bn : r_bd;
            end
            default: begin
                w_mx = r_an;
                w_my = r_bd;
            end
        endcase
    end

    assign w_prod = w_mx * w_my;

    // Combine products (or operand a for increment and decrement) into the raw fraction, wrapping at RW bits
    always_comb begin
        case (r_func)
            FUNC_ADD: begin
                w_rn = RW'(r_p0) + RW'(r_p1);
                w_rd = RW'(r_pd);
            end
            FUNC_SUB: begin
                w_rn = RW'(r_p0) - RW'(r_p1);
                w_rd = RW'(r_pd);
            end
            FUNC_MUL, FUNC_DIV: begin
                w_rn = RW'(r_p0);
                w_rd = RW'(r_pd);
            end
            FUNC_INC: begin
                w_rn = RW'(r_an) + RW'(r_ad);
                w_rd = RW'(r_ad);
            end
            FUNC_DEC: begin
                w_rn = RW'(r_an) - RW'(r_ad);
                w_rd = RW'(r_ad);
            end
            default: begin
                w_rn = '0;
                w_rd = RW'(1);
            end
        endcase
    end

    // Absolute values of the raw fraction
    assign w_nmag = r_rn[RW-1] ? (RW'(0) - r_rn) : r_rn;
    assign w_dmag = r_rd[RW-1] ? (RW'(0) - r_rd) : r_rd;

    // Binary GCD step terms
    assign w_u_gt     = r_u > r_v;
    assign w_diff     = w_u_gt ? (r_u - r_v) : (r_v - r_u);
    assign w_gcd_done = r_zero || (r_u == r_v);

    // Restoring divider lanes sharing divisor r_g
    assign w_tn     = {r_mn, r_qn[RW-1]};
    assign w_td     = {r_md, r_qd[RW-1]};
    assign w_tn_sub = w_tn - {1'b0, r_g};
    assign w_td_sub = w_td - {1'b0, r_g};
    assign w_gen    = w_tn >= {1'b0, r_g};
    assign w_ged    = w_td >= {1'b0, r_g};

    // Reapply the result sign and fit to the output widths
    assign w_qn_ext = OW'(r_qn);
    assign w_num_s  = r_neg ? (OW'(0) - w_qn_ext) : w_qn_ext;
    assign w_qd_ext = DW'(r_qd);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_an   <= i_a_num;
            r_ad   <= i_a_den;
            r_bn   <= i_b_num;
            r_bd   <= i_b_den;
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                MS_NUM0: r_p0 <= w_prod;
                MS_NUM1: r_p1 <= w_prod;
                MS_DEN:  r_pd <= w_prod;
                default: r_p0 <= w_prod;
            endcase
        end
        if (i_cmd.comb) begin
            r_rn <= w_rn;
            r_rd <= w_rd;
        end
        // Seed the GCD with the magnitudes
        if (i_cmd.mag) begin
            r_neg  <= r_rn[RW-1] ^ r_rd[RW-1];
            r_zero <= (w_nmag == '0) || (w_dmag == '0);
            r_qn   <= w_nmag;
            r_qd   <= w_dmag;
            r_u    <= w_nmag;
            r_v    <= w_dmag;
            r_k    <= '0;
        end
        // Advance the GCD by one shift or subtract
        if (i_cmd.gcd_step) begin
            if (!r_u[0] && !r_v[0]) begin
                r_u <= r_u >> 1;
                r_v <= r_v >> 1;
                r_k <= r_k + KW'(1);
            end else if (!r_u[0]) begin
                r_u <= r_u >> 1;
            end else if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else if (w_u_gt) begin
                r_u <= w_diff >> 1;
            end else begin
                r_v <= w_diff >> 1;
            end
        end
        if (i_cmd.div_init) begin
            r_g   <= r_zero ? RW'(1) : (r_u << r_k);
            r_mn  <= '0;
            r_md  <= '0;
            r_cnt <= CW'(RW);
        end
        // Shift one quotient bit into each lane
        if (i_cmd.div_step) begin
            r_qn  <= {r_qn[RW-2:0], w_gen};
            r_qd  <= {r_qd[RW-2:0], w_ged};
            r_mn  <= w_gen ? w_tn_sub[RW-1:0] : w_tn[RW-1:0];
            r_md  <= w_ged ? w_td_sub[RW-1:0] : w_td[RW-1:0];
            r_cnt <= r_cnt - CW'(1);
        end
        if (i_cmd.out_load) begin
            r_res_num <= w_num_s[RES_NUM_W-1:0];
            r_res_den <= w_qd_ext[RES_DEN_W-1:0];
            r_dz      <= (r_qd == '0);
        end
    end

    assign o_status.gcd_done = w_gcd_done;
    assign o_status.div_done = (r_cnt == '0);
    assign o_res_num         = r_res_num;
    assign o_res_den         = r_res_den;
    assign o_div_by_zero     = r_dz;

endmodule

// ----- hw/rtl/rar_ctrl.sv -----
// Controller: sequences multiply, reduce and divide steps and owns the handshakes.
`include "rational_arith_reduce_top_defines.svh"
module rar_ctrl import rar_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_N0,
        ST_MUL_N1,
        ST_MUL_D,
        ST_COMB,
        ST_MAG,
        ST_GCD,
        ST_DIV_INIT,
        ST_DIV,
        ST_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_m_tvalid, n_m_tvalid;
    logic   w_slot_free;

    assign w_slot_free = !r_m_tvalid || i_m_tready;

    // Decode commands and next state
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.mul_sel = MS_NUM0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL_N0;
                end
            end
            ST_MUL_N0: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_NUM0;
                n_state       = ST_MUL_N1;
            end
            ST_MUL_N1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_NUM1;
                n_state       = ST_MUL_D;
            end
            ST_MUL_D: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_DEN;
                n_state       = ST_COMB;
            end
            ST_COMB: begin
                o_cmd.comb = 1'b1;
                n_state    = ST_MAG;
            end
            ST_MAG: begin
                o_cmd.mag = 1'b1;
                n_state   = ST_GCD;
            end
            ST_GCD: begin
                if (i_status.gcd_done) begin
                    n_state = ST_DIV_INIT;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            ST_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            ST_DONE: begin
                if (w_slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold the result valid until the transaction completes
    always_comb begin
        if (o_cmd.out_load) begin
            n_m_tvalid = 1'b1;
        end else if (r_m_tvalid && i_m_tready) begin
            n_m_tvalid = 1'b0;
        end else begin
            n_m_tvalid = r_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_m_tvalid;

    `RAR_ASSERT_NEXT(a_accept_starts, i_s_tvalid && o_s_tready, r_state == ST_MUL_N0,
        "accepted transaction did not start the multiply sequence")
    `RAR_ASSERT_SAME(a_load_slot_free, o_cmd.out_load, !r_m_tvalid || i_m_tready,
        "result loaded over an untaken output")
    `RAR_ASSERT_SAME(a_valid_after_done, $rose(r_m_tvalid), $past(r_state) == ST_DONE,
        "output valid rose outside the done step")
    `RAR_ASSERT_SAME(a_no_step_when_done, o_cmd.gcd_step, !i_status.gcd_done,
        "GCD stepped after convergence")

endmodule

// ----- hw/rtl/rational_arith_reduce_top.sv -----
// Top level of the rational arithmetic unit with GCD reduction.
//
// Usage: one fraction pair and an operation enter on the slave stream; one
// reduced fraction leaves on the master stream for each accepted transaction.
// i_s_tuser carries the operation (add, subtract, multiply, divide, increment
// a, decrement a); i_s_tdata carries a_num, a_den, b_num, b_den.
// o_m_tdata carries res_num then res_den; o_m_tuser is the divide-by-zero flag.
// Sequence, with RW = min(2*WIDTH+1, 64): three products on the shared
// multiplier, a combine step and a magnitude step, the binary GCD (one
// shift or subtract per cycle plus the convergence check), a divider setup
// step, the bit-serial divider that forms both RW-bit quotients, and the
// output load. The next transaction is accepted in the cycle after the
// output load at the earliest.
// One transaction is in work at a time; o_s_tready is high only while idle.
// The output register lets a new transaction start while a result waits;
// while the receiver stalls, the finished result waits in the done step.
// Reset clears the controller and the output valid; no result is pending.
module rational_arith_reduce_top import rar_pkg::*; #(
    parameter int WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // a_num, a_den, b_num, b_den (WIDTH bits each), zero padded to bytes
    input  logic [((4*WIDTH+7)/8)*8-1:0] i_s_tdata,
    // func
    input  logic [FUNC_W-1:0]           i_s_tuser,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // res_num (33 bits), res_den (31 bits)
    output logic [RES_NUM_W+RES_DEN_W-1:0] o_m_tdata,
    // div_by_zero
    output logic                        o_m_tuser
);

    t_dp_cmd                     w_cmd;
    t_dp_status                  w_status;
    logic signed [RES_NUM_W-1:0] w_res_num;
    logic [RES_DEN_W-1:0]        w_res_den;

    rar_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    rar_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_cmd         (w_cmd),
        .i_func        (i_s_tuser),
        .i_a_num       (i_s_tdata[WIDTH-1:0]),
        .i_a_den       (i_s_tdata[2*WIDTH-1:WIDTH]),
        .i_b_num       (i_s_tdata[3*WIDTH-1:2*WIDTH]),
        .i_b_den       (i_s_tdata[4*WIDTH-1:3*WIDTH]),
        .o_status      (w_status),
        .o_res_num     (w_res_num),
        .o_res_den     (w_res_den),
        .o_div_by_zero (o_m_tuser)
    );

    assign o_m_tdata = {w_res_den, w_res_num};

endmodule

// ----- tb/rational_arith_reduce_top_tb.sv -----
// Self-checking testbench for the rational arithmetic unit with GCD reduction.
`timescale 1ns / 100ps

module rational_arith_reduce_top_tb import rar_pkg::*;;

    localparam int OPW = 16;

    // Operation codes the block reduces to the fraction 0/1
    localparam logic [FUNC_W-1:0] FUNC_RSVD6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_RSVD7 = 3'd7;

    // Cycles to let the block drain after the last expected result
    localparam int DRAIN_CYCLES = 200;

    typedef logic signed [OPW-1:0] t_operand;

    typedef struct {
        logic [FUNC_W-1:0]    func;
        logic [RES_NUM_W-1:0] num;
        logic [RES_DEN_W-1:0] den;
        logic                 dz;
    } t_reduced_frac;

    // Predicts reduced fractions and checks them against the output stream
    class frac_scoreboard;
        t_reduced_frac fracs_due[$];
        int            errors;
        int            results_seen;
        int            dz_seen;
        int            op_count[8];

        function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
            longint unsigned t;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            return x;
        endfunction

        // Form the raw fraction, reduce it and move the sign to the numerator
        function automatic t_reduced_frac reduce_fraction(logic [FUNC_W-1:0] func,
                                                          t_operand a_num, t_operand a_den,
                                                          t_operand b_num, t_operand b_den);
            longint          an, ad, bn, bd, rn, rd;
            longint unsigned nmag, dmag, g;
            bit              neg;
            t_reduced_frac   r;
            an = a_num;
            ad = a_den;
            bn = b_num;
            bd = b_den;
            case (func)
                FUNC_ADD: begin
                    rn = an * bd + bn * ad;
                    rd = ad * bd;
                end
                FUNC_SUB: begin
                    rn = an * bd - bn * ad;
                    rd = ad * bd;
                end
                FUNC_MUL: begin
                    rn = an * bn;
                    rd = ad * bd;
                end
                FUNC_DIV: begin
                    rn = an * bd;
                    rd = ad * bn;
                end
                FUNC_INC: begin
                    rn = an + ad;
                    rd = ad;
                end
                FUNC_DEC: begin
                    rn = an - ad;
                    rd = ad;
                end
                default: begin
                    rn = 0;
                    rd = 1;
                end
            endcase
            nmag = (rn < 0) ? longint'(-rn) : rn;
            dmag = (rd < 0) ? longint'(-rd) : rd;
            g = (nmag != 0 && dmag != 0) ? gcd_of(nmag, dmag) : 64'd1;
            nmag = nmag / g;
            dmag = dmag / g;
            neg = (rn < 0) != (rd < 0);
            r.func = func;
            r.num  = RES_NUM_W'(neg ? (64'd0 - nmag) : nmag);
            r.den  = RES_DEN_W'(dmag);
            r.dz   = (dmag == 0);
            return r;
        endfunction

        // Queue the expected result of an accepted operand transaction
        function void note_operands(logic [FUNC_W-1:0] func, t_operand a_num, t_operand a_den,
                                    t_operand b_num, t_operand b_den);
            fracs_due.push_back(reduce_fraction(func, a_num, a_den, b_num, b_den));
            op_count[func]++;
        endfunction

        function void flag(string what);
            errors++;
            if (errors <= 10)
                $display("ERROR @%0t: %s", $realtime, what);
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(logic [RES_NUM_W-1:0] num, logic [RES_DEN_W-1:0] den,
                                   logic dz);
            t_reduced_frac e;
            results_seen++;
            if (dz)
                dz_seen++;
            if (fracs_due.size() == 0) begin
                flag($sformatf("unexpected result num=%0h den=%0h dz=%0b", num, den, dz));
                return;
            end
            e = fracs_due.pop_front();
            if (num !== e.num)
                flag($sformatf("func %0d res_num exp %0h got %0h", e.func, e.num, num));
            if (den !== e.den)
                flag($sformatf("func %0d res_den exp %0h got %0h", e.func, e.den, den));
            if (dz !== e.dz)
                flag($sformatf("func %0d div_by_zero exp %0b got %0b", e.func, e.dz, dz));
        endfunction

        function int waiting();
            return fracs_due.size();
        endfunction

        // Count expectations that never got a result
        function void close_out();
            if (fracs_due.size() != 0)
                flag($sformatf("%0d results never arrived", fracs_due.size()));
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_s_tvalid;
    logic                           o_s_tready;
    logic [((4*OPW+7)/8)*8-1:0]     i_s_tdata;   // a_num, a_den, b_num, b_den
    logic [FUNC_W-1:0]              i_s_tuser;   // func
    logic                           o_m_tvalid;
    logic                           i_m_tready;
    logic [RES_NUM_W+RES_DEN_W-1:0] o_m_tdata;   // res_num, res_den
    logic                           o_m_tuser;   // div_by_zero

    frac_scoreboard sb;
    int             send_idle_pct;
    int             recv_idle_pct;
    int             rx_hold_left;

    rational_arith_reduce_top #(
        .WIDTH(OPW)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Offer one operand transaction and hold it until accepted
    task automatic send_operands(logic [FUNC_W-1:0] func, t_operand a_num, t_operand a_den,
                                 t_operand b_num, t_operand b_den);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= func;
        i_s_tdata  <= {b_den, b_num, a_den, a_num};
        do
            @(posedge i_clk);
        while (!o_s_tready);
        sb.note_operands(func, a_num, a_den, b_num, b_den);
    endtask

    // Mix zeros, small values with common factors, extremes and full-range noise
    function automatic t_operand pick_operand();
        int sel;
        sel = $urandom_range(99);
        if (sel < 8)
            return '0;
        if (sel < 40)
            return t_operand'($urandom_range(128) - 64);
        if (sel < 50) begin
            case ($urandom_range(3))
                0: return 16'sh8000;
                1: return 16'sh7fff;
                2: return -16'sd1;
                default: return 16'sd1;
            endcase
        end
        if (sel < 60)
            return t_operand'(($urandom_range(255) - 128) * 64);
        return t_operand'($urandom);
    endfunction

    function automatic logic [FUNC_W-1:0] pick_func();
        if ($urandom_range(99) < 4)
            return $urandom_range(1) ? FUNC_RSVD6 : FUNC_RSVD7;
        return FUNC_W'($urandom_range(5));
    endfunction

    task automatic send_random(int count);
        repeat (count)
            send_operands(pick_func(), pick_operand(), pick_operand(), pick_operand(),
                          pick_operand());
    endtask

    // Stall the stimulus until every expected result has arrived
    task automatic wait_for_results();
        while (sb.waiting() != 0)
            @(posedge i_clk);
    endtask

    // Receive results, with random stalls and an optional long hold-off
    initial begin
        i_m_tready = 1'b0;
        while (i_rst_n !== 1'b1)
            @(posedge i_clk);
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready)
                sb.check_result(o_m_tdata[RES_NUM_W-1:0],
                                o_m_tdata[RES_NUM_W+RES_DEN_W-1:RES_NUM_W], o_m_tuser);
        end
    end

    // Stop a hung run
    initial begin
        #2_000_000;
        $display("rational_arith_reduce_top verification failed");
        $finish;
    end

    initial begin
        sb            = new();
        send_idle_pct = 9;
        recv_idle_pct = 69;
        rx_hold_left  = 0;
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tuser     = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: each operation, unused codes, zero parts and extremes
        send_operands(FUNC_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
        send_operands(FUNC_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2);
        send_operands(FUNC_MUL, -16'sd3, 16'sd4, 16'sd2, -16'sd9);
        send_operands(FUNC_DIV, 16'sd3, 16'sd4, 16'sd0, 16'sd5);
        send_operands(FUNC_INC, 16'sd7, -16'sd3, 16'sd11, 16'sd13);
        send_operands(FUNC_DEC, -16'sd5, 16'sd0, -16'sd1, -16'sd1);
        send_operands(FUNC_RSVD6, 16'sh7fff, 16'sh8000, 16'sh1234, 16'sh0000);
        send_operands(FUNC_RSVD7, 16'sh0000, 16'sh0000, 16'shffff, 16'sh8000);
        send_operands(FUNC_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_operands(FUNC_MUL, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
        send_operands(FUNC_SUB, 16'sh7fff, 16'sd1, 16'sh8000, 16'sd1);
        send_operands(FUNC_DIV, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
        send_operands(FUNC_INC, 16'sh7fff, 16'sh7fff, 16'sd0, 16'sd0);
        send_operands(FUNC_DEC, 16'sh8000, 16'sh7fff, 16'sd0, 16'sd0);
        send_operands(FUNC_MUL, 16'sd0, 16'sd0, 16'sd5, 16'sd7);
        send_operands(FUNC_ADD, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_operands(FUNC_DIV, 16'sd0, 16'sd1, 16'sd0, 16'sd1);
        send_operands(FUNC_ADD, 16'sd1024, 16'sd4096, 16'sd2048, 16'sd8192);
        send_operands(FUNC_INC, 16'sd0, -16'sd7, 16'sd0, 16'sd0);
        send_operands(FUNC_DEC, 16'sd5, 16'sd5, 16'sd0, 16'sd0);
        send_operands(FUNC_SUB, -16'sd1, -16'sd1, 16'sd1, 16'sd1);
        send_operands(FUNC_MUL, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
        send_operands(FUNC_DIV, 16'sh7fff, -16'sd1, 16'sh8000, -16'sd1);
        send_operands(FUNC_ADD, 16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        wait_for_results();

        // Random, slow receiver
        send_random(160);

        // Random, slow sender
        send_idle_pct = 69;
        recv_idle_pct = 9;
        send_random(160);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        wait_for_results();

        // Random, no idling; hold off the receiver so the input backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(1);
        rx_hold_left = 400;
        send_random(159);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.close_out();

        $display("Covered: add %0d, sub %0d, mul %0d, div %0d, inc %0d, dec %0d, unused %0d",
                 sb.op_count[FUNC_ADD], sb.op_count[FUNC_SUB], sb.op_count[FUNC_MUL],
                 sb.op_count[FUNC_DIV], sb.op_count[FUNC_INC], sb.op_count[FUNC_DEC],
                 sb.op_count[FUNC_RSVD6] + sb.op_count[FUNC_RSVD7]);
        $display("Checked %0d results (%0d divide-by-zero) under stalls and a long hold-off",
                 sb.results_seen, sb.dz_seen);
        if (sb.errors == 0) begin
            $display("rational_arith_reduce_top verification clean");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("rational_arith_reduce_top verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/rar_pkg.sv
hw/rtl/rar_dp.sv
hw/rtl/rar_ctrl.sv
hw/rtl/rational_arith_reduce_top.sv
tb/rational_arith_reduce_top_tb.sv
